### src/slcd_pkg.sv
// Shared types and constants of the sync/length/checksum deframer.
package slcd_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 6;
  localparam int POS_W           = 5;
  localparam int COUNT_W         = 32;
  localparam int DEF_MAX_PAYLOAD = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_IDX_W       = 1;

  localparam logic [BYTE_W-1:0] SYNC_RESET       = 8'hAA;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET = 6'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_SUM  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_value;
    logic [LEN_W-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [LEN_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic               bank;
    logic [LEN_W-1:0]   len;
    logic [COUNT_W-1:0] count;
  } frame_desc_t;

endpackage

### src/sync_length_checksum_deframer.sv
// Top level of the sync/length/checksum deframer.
//
// The deframer takes one received byte per request and hunts for frames made
// of a sync byte, a length byte from 1 to min(max_length, MAX_PAYLOAD), that
// many payload bytes and an 8-bit additive checksum over sync, length and
// payload. A frame whose checksum matches bumps a wrapping 32-bit frame count
// and its payload is sent out as one request per byte, the final byte marked
// by last_byte; every failure silently returns to hunting for sync. The
// parser takes one input byte every cycle unless in_stall is high. Payload
// bytes go into a two-bank store of 2*MAX_PAYLOAD bytes, and a two-entry
// descriptor queue hands good frames to the replay side, which sends one
// byte per cycle unless out_stall holds it, through a registered memory
// read and an output register. The input stalls only while two good frames
// are still waiting for replay and a third frame has reached its payload or
// checksum byte; it resumes the cycle after the oldest frame's last byte has
// been read from the store. Configuration is written through cfg_write,
// cfg_index and cfg_data while the block is idle; the user must keep to
// this, as the block itself does not enforce it.
module sync_length_checksum_deframer import slcd_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    payload_byte,
  output logic [POS_W-1:0]     byte_position,
  output logic                 last_byte,
  output logic [LEN_W-1:0]     frame_length,
  output logic [COUNT_W-1:0]   good_frame_count
);

  cfg_t        cfg;
  mem_wr_t     mem_wr;
  logic        push;
  frame_desc_t push_desc;
  logic        pop;
  logic        head_valid;
  frame_desc_t head;
  logic        q_full;

  // Configuration registers; the sync byte and the length limit take effect
  // at the next byte that uses them.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value <= SYNC_RESET;
      cfg.max_length <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SYNC_VALUE: cfg.sync_value <= cfg_data;
        CFG_MAX_LENGTH: cfg.max_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  slcd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .rx_byte   (rx_byte),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .mem_wr    (mem_wr)
  );

  slcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (q_full)
  );

  slcd_replay #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_replay (
    .clk              (clk),
    .rst              (rst),
    .mem_wr           (mem_wr),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .payload_byte     (payload_byte),
    .byte_position    (byte_position),
    .last_byte        (last_byte),
    .frame_length     (frame_length),
    .good_frame_count (good_frame_count)
  );

endmodule

### src/slcd_parser.sv
// Front part: byte-by-byte frame parser with checksum and payload capture.
module slcd_parser import slcd_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              in_stall,
  input  logic              q_full,
  output logic              push,
  output frame_desc_t       push_desc,
  output mem_wr_t           mem_wr
);

  localparam logic [BYTE_W-1:0] PAYLOAD_CAP = BYTE_W'(MAX_PAYLOAD);

  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  sum, sum_next;
  logic [LEN_W-1:0]   exp_len, exp_len_next;
  logic [LEN_W-1:0]   fill, fill_next;
  logic               wbank, wbank_next;
  logic [COUNT_W-1:0] frames, frames_next;

  logic              accept;
  logic [BYTE_W-1:0] cfg_len;
  logic [BYTE_W-1:0] limit;
  logic [LEN_W-1:0]  fill_inc;
  logic              sum_ok;

  // Payload and checksum bytes wait while both store banks hold frames
  // that are still being replayed.
  assign in_stall = q_full && (phase == PH_DATA || phase == PH_SUM);
  assign accept   = in_valid && !in_stall;

  assign cfg_len  = {{(BYTE_W-LEN_W){1'b0}}, cfg.max_length};
  assign limit    = (cfg_len > PAYLOAD_CAP) ? PAYLOAD_CAP : cfg_len;
  assign fill_inc = fill + 1'b1;
  assign sum_ok   = (rx_byte == sum);

  always_comb begin
    phase_next   = phase;
    sum_next     = sum;
    exp_len_next = exp_len;
    fill_next    = fill;
    wbank_next   = wbank;
    frames_next  = frames;
    if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == cfg.sync_value) begin
            sum_next   = cfg.sync_value;
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (rx_byte != '0 && rx_byte <= limit) begin
            exp_len_next = rx_byte[LEN_W-1:0];
            fill_next    = '0;
            sum_next     = sum + rx_byte;
            phase_next   = PH_DATA;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_DATA: begin
          sum_next  = sum + rx_byte;
          fill_next = fill_inc;
          if (fill_inc >= exp_len) begin
            phase_next = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_next = PH_HUNT;
          if (sum_ok) begin
            frames_next = frames + 1'b1;
            wbank_next  = ~wbank;
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      sum     <= '0;
      exp_len <= '0;
      fill    <= '0;
      wbank   <= 1'b0;
      frames  <= '0;
    end else begin
      phase   <= phase_next;
      sum     <= sum_next;
      exp_len <= exp_len_next;
      fill    <= fill_next;
      wbank   <= wbank_next;
      frames  <= frames_next;
    end
  end

  assign mem_wr.en   = accept && (phase == PH_DATA);
  assign mem_wr.bank = wbank;
  assign mem_wr.addr = fill;
  assign mem_wr.data = rx_byte;

  assign push            = accept && (phase == PH_SUM) && sum_ok;
  assign push_desc.bank  = wbank;
  assign push_desc.len   = exp_len;
  assign push_desc.count = frames + 1'b1;

endmodule

### src/slcd_queue.sv
// Two-entry queue of accepted frame descriptors between parser and replay.
module slcd_queue import slcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_desc_t push_desc,
  input  logic        pop,
  output logic        head_valid,
  output frame_desc_t head,
  output logic        full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_desc_t        entry [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/slcd_replay.sv
// Back part: two-bank payload store and the replay pipeline to the output.
module slcd_replay import slcd_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic               clk,
  input  logic               rst,
  input  mem_wr_t            mem_wr,
  input  logic               head_valid,
  input  frame_desc_t        head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  payload_byte,
  output logic [POS_W-1:0]   byte_position,
  output logic               last_byte,
  output logic [LEN_W-1:0]   frame_length,
  output logic [COUNT_W-1:0] good_frame_count
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0] mem [2][MAX_PAYLOAD];

  logic [LEN_W-1:0]   rd_pos;
  logic               rd_last;
  logic               issue;
  logic               out_free;

  logic               s1_valid;
  logic [BYTE_W-1:0]  s1_data;
  logic [POS_W-1:0]   s1_pos;
  logic               s1_last;
  logic [LEN_W-1:0]   s1_len;
  logic [COUNT_W-1:0] s1_count;

  assign out_free = !out_valid || !out_stall;
  assign issue    = head_valid && (!s1_valid || out_free);
  assign rd_last  = (rd_pos + 1'b1 == head.len);
  // The head frame's bank is released once its last byte has been read.
  assign pop      = issue && rd_last;

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.bank][AW'(mem_wr.addr)] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_data  <= mem[head.bank][AW'(rd_pos)];
      s1_pos   <= rd_pos[POS_W-1:0];
      s1_last  <= rd_last;
      s1_len   <= head.len;
      s1_count <= head.count;
    end
    if (s1_valid && out_free) begin
      payload_byte     <= s1_data;
      byte_position    <= s1_pos;
      last_byte        <= s1_last;
      frame_length     <= s1_len;
      good_frame_count <= s1_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pos    <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        rd_pos <= rd_last ? '0 : rd_pos + 1'b1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

### src/slcd_checker.sv
// Port-level checks of the deframer and their binding to the top level.
module slcd_checker import slcd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_write,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [BYTE_W-1:0]    cfg_data,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [BYTE_W-1:0]    rx_byte,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [BYTE_W-1:0]    payload_byte,
  input logic [POS_W-1:0]     byte_position,
  input logic                 last_byte,
  input logic [LEN_W-1:0]     frame_length,
  input logic [COUNT_W-1:0]   good_frame_count
);

  // A stalled request keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_byte) &&
      $stable(byte_position) && $stable(good_frame_count))
    else $error("output request changed while stalled");

  // The final byte of a frame sits at position length minus one.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> byte_position == POS_W'(frame_length - 1'b1))
    else $error("last byte at wrong position");

  // Any other byte lies inside the frame.
  a_mid_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_byte |->
      (LEN_W'(byte_position) + 1'b1) < frame_length)
    else $error("byte position beyond frame length");

  // Reported frames are never empty.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_length != '0)
    else $error("zero frame length on output");

  // Reset empties the output.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (.*);
